// File: rtl/core/gss_pkg.sv
// Package for the granular sample synth: sizes, codes, types and helpers.
package gss_pkg;

   localparam int MAX_LAYERS   = 16;
   localparam int WINDOW_DEPTH = 512;
   localparam int SAMPLE_DEPTH = 65536;

   localparam int WIN_AW   = $clog2(WINDOW_DEPTH);
   localparam int SMP_AW   = $clog2(SAMPLE_DEPTH);
   localparam int PHASE_W  = WIN_AW + 16;
   localparam int LAYER_W  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int LCNT_W   = $clog2(MAX_LAYERS + 1);
   localparam int ACC_W    = 52;

   localparam logic [31:0] LFSR_MASK  = 32'h8020_0003;
   localparam logic [31:0] PHASE_WRAP = 32'(WINDOW_DEPTH) << 16;
   localparam int          AMP_INT    = (2 * 327680 + 7 * MAX_LAYERS) / (14 * MAX_LAYERS);
   localparam logic [15:0] AMP_Q15    = 16'(AMP_INT);
   localparam logic [15:0] MIN_DUR    = 16'd2;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_SAMPLE = 2'd1,
      FUNC_WINDOW = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      REG_READ_LOW   = 3'd0,
      REG_READ_HIGH  = 3'd1,
      REG_DUR_LOW    = 3'd2,
      REG_DUR_HIGH   = 3'd3,
      REG_LAYERS     = 3'd4,
      REG_GAIN       = 3'd5,
      REG_SEED       = 3'd6,
      REG_SPARE      = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_GRAIN, ST_RAND_DUR, ST_WAIT_DUR, ST_STEP_DIV, ST_WAIT_STEP,
      ST_RAND_POS, ST_WAIT_POS, ST_READ, ST_MUL1, ST_MUL2, ST_NEXT,
      ST_FIN1, ST_FIN2, ST_FIN3, ST_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [16:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic [16:0] remainder;
   } div_rsp_type;

   function automatic logic [31:0] lfsr_next(input logic [31:0] s);
      logic [31:0] t;
      t = s >> 1;
      if (s[0]) t = t ^ LFSR_MASK;
      return t;
   endfunction

endpackage

// File: rtl/core/gss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/core/gss_div.sv
// Shared restoring divider: 32-bit dividend by 17-bit divisor, one bit per cycle.
module gss_div (
   input  logic                 clock,
   input  logic                 reset,
   input  gss_pkg::div_req_type req,
   output gss_pkg::div_rsp_type rsp
);
   import gss_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [17:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [16:0] dvs_ff, dvs_in;
   logic [17:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff[16:0], quo_ff[31]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         rem_in  = 18'd0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         // quotient bits shift in from the bottom as dividend bits leave the top
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff[16:0];
endmodule

// File: rtl/core/granular_sample_synth_core.sv
// Top level of the granular sample synth: sequencer, grain state and output stage.
//
//  channel | ports            | payload (low bit up)
//  --------+------------------+-----------------------------------------------
//  input   | req_t*           | tuser: func[1:0]; tdata: address, write_data
//  result  | rsp_t*           | tuser: is_sample, clipped; tdata: sample_out
//  config  | csr_we/index/wdata | index 0..6, data in low bits
//
// A write beat is accepted and then handed off. A tick is accepted, then walks
// each active grain (states GRAIN, READ, MUL1, MUL2, NEXT), runs three passes
// of the shared divider for each grain draw, each pass with a launch state, and
// ends with rounding, gain and hand-off.
// Reset is synchronous and holds req_tready low; no clearing pass, the stores
// are undefined until written.
// A finished result waits in the output register; the next beat is taken while
// it waits, and a later result stalls only if the earlier one is still unread.
module granular_sample_synth_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // func
   input  logic [31:0] req_tdata,   // address[15:0], write_data[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // is_sample[0], clipped[1]
   output logic [15:0] rsp_tdata,   // sample_out
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import gss_pkg::*;

   // configuration
   logic [15:0]        read_low_ff, read_high_ff, dur_low_ff, dur_high_ff;
   logic [LCNT_W-1:0]  layers_ff;
   logic signed [15:0] gain_ff;
   logic [31:0]        lfsr_ff, lfsr_in;

   // per-grain state
   logic [PHASE_W-1:0] phase_ff [MAX_LAYERS];
   logic [PHASE_W-1:0] step_ff  [MAX_LAYERS];
   logic [15:0]        pos_ff   [MAX_LAYERS];
   logic [15:0]        start_ff [MAX_LAYERS];
   logic [MAX_LAYERS-1:0] draw_ff;

   state_type          state_ff, state_in;
   logic [LAYER_W-1:0] g_ff, g_in;
   logic               redraw_ff, redraw_in;
   logic [15:0]        dur_ff, dur_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [31:0] prod_ff, prod_in;
   logic signed [23:0] accq_ff, accq_in;
   logic signed [39:0] y_ff, y_in;
   logic [15:0]        res_data_ff, res_data_in;
   logic               res_smp_ff, res_smp_in, res_clip_ff, res_clip_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_smp_ff, rsp_smp_in, rsp_clip_ff, rsp_clip_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // grain update strobes
   logic               set_step, set_pos, upd_grain;
   logic [PHASE_W:0]   phase_sum;
   logic [PHASE_W-1:0] phase_new;
   logic               wrapped;
   logic [16:0]        pos_inc;
   logic [15:0]        pos_new;

   // draw ranges
   logic [15:0] da, db, dlo, dhi, rlo, rhi;
   logic [16:0] dur_range, rd_range;

   logic        accept;
   func_type    func;
   logic        ram_we_smp, ram_we_win;
   logic signed [15:0] win_rd, smp_rd;
   logic signed [47:0] amp_prod;
   logic signed [27:0] y_round;
   logic [LCNT_W-1:0]  g_next;

   assign func   = func_type'(req_tuser);
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && !reset;

   assign ram_we_smp = accept && (func == FUNC_SAMPLE);
   assign ram_we_win = accept && (func == FUNC_WINDOW);

   gss_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
      .clock (clock),
      .we    (ram_we_smp),
      .waddr (SMP_AW'(req_tdata[15:0])),
      .wdata (req_tdata[31:16]),
      .raddr (SMP_AW'(pos_ff[g_ff])),
      .rdata (smp_rd)
   );

   gss_ram #(.WIDTH(16), .DEPTH(WINDOW_DEPTH)) u_window_ram (
      .clock (clock),
      .we    (ram_we_win),
      .waddr (WIN_AW'(req_tdata[15:0])),
      .wdata (req_tdata[31:16]),
      .raddr (phase_ff[g_ff][PHASE_W-1:16]),
      .rdata (win_rd)
   );

   gss_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ranges: durations raised to at least two, reversed bounds swapped
   always_comb begin
      da = (dur_low_ff  < MIN_DUR) ? MIN_DUR : dur_low_ff;
      db = (dur_high_ff < MIN_DUR) ? MIN_DUR : dur_high_ff;
      dlo = (da < db) ? da : db;
      dhi = (da < db) ? db : da;
      rlo = (read_low_ff < read_high_ff) ? read_low_ff  : read_high_ff;
      rhi = (read_low_ff < read_high_ff) ? read_high_ff : read_low_ff;
      dur_range = {1'b0, dhi} - {1'b0, dlo} + 17'd1;
      rd_range  = {1'b0, rhi} - {1'b0, rlo} + 17'd1;
   end

   // phase and position advance for the current grain, amplitude scaling, output rounding and next grain index
   always_comb begin
      phase_sum = {1'b0, phase_ff[g_ff]} + {1'b0, step_ff[g_ff]};
      wrapped   = (phase_sum >= (PHASE_W+1)'(PHASE_WRAP));
      phase_new = wrapped ? PHASE_W'(phase_sum - (PHASE_W+1)'(PHASE_WRAP))
                          : phase_sum[PHASE_W-1:0];
      pos_inc   = {1'b0, pos_ff[g_ff]} + 17'd1;
      pos_new   = (pos_inc >= {1'b0, read_high_ff}) ? start_ff[g_ff] : pos_inc[15:0];
      amp_prod  = prod_ff * $signed({1'b0, AMP_Q15});
      y_round   = 28'((y_ff + 40'sd2048) >>> 12);
      g_next    = LCNT_W'(g_ff) + LCNT_W'(1);
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      g_in        = g_ff;
      redraw_in   = redraw_ff;
      dur_in      = dur_ff;
      acc_in      = acc_ff;
      prod_in     = prod_ff;
      accq_in     = accq_ff;
      y_in        = y_ff;
      res_data_in = res_data_ff;
      res_smp_in  = res_smp_ff;
      res_clip_in = res_clip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_smp_in  = rsp_smp_ff;
      rsp_clip_in = rsp_clip_ff;
      lfsr_in     = lfsr_ff;
      div_req     = '0;
      set_step    = 1'b0;
      set_pos     = 1'b0;
      upd_grain   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_data_in = 16'd0;
               res_smp_in  = 1'b0;
               res_clip_in = 1'b0;
               g_in        = '0;
               acc_in      = '0;
               state_in    = (func == FUNC_TICK) ? ST_GRAIN : ST_DONE;
            end
         end
         ST_GRAIN: begin
            redraw_in = 1'b0;
            state_in  = draw_ff[g_ff] ? ST_RAND_DUR : ST_READ;
         end
         ST_RAND_DUR: begin
            lfsr_in          = lfsr_next(lfsr_ff);
            div_req.start    = 1'b1;
            div_req.dividend = lfsr_next(lfsr_ff);
            div_req.divisor  = dur_range;
            state_in         = ST_WAIT_DUR;
         end
         ST_WAIT_DUR: begin
            if (div_rsp.done) begin
               dur_in   = dlo + div_rsp.remainder[15:0];
               state_in = ST_STEP_DIV;
            end
         end
         ST_STEP_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = PHASE_WRAP;
            div_req.divisor  = {1'b0, dur_ff};
            state_in         = ST_WAIT_STEP;
         end
         ST_WAIT_STEP: begin
            if (div_rsp.done) begin
               set_step = 1'b1;
               state_in = ST_RAND_POS;
            end
         end
         ST_RAND_POS: begin
            lfsr_in          = lfsr_next(lfsr_ff);
            div_req.start    = 1'b1;
            div_req.dividend = lfsr_next(lfsr_ff);
            div_req.divisor  = rd_range;
            state_in         = ST_WAIT_POS;
         end
         ST_WAIT_POS: begin
            if (div_rsp.done) begin
               set_pos  = 1'b1;
               // a wrap redraw ends the grain; a first draw goes on to play it
               state_in = redraw_ff ? ST_NEXT : ST_READ;
            end
         end
         ST_READ:  state_in = ST_MUL1;
         ST_MUL1: begin
            prod_in  = win_rd * smp_rd;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            acc_in    = acc_ff + ACC_W'(amp_prod);
            upd_grain = 1'b1;
            if (wrapped) begin
               redraw_in = 1'b1;
               state_in  = ST_RAND_DUR;
            end else begin
               state_in  = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (g_next >= layers_ff) begin
               state_in = ST_FIN1;
            end else begin
               g_in     = LAYER_W'(g_next);
               state_in = ST_GRAIN;
            end
         end
         ST_FIN1: begin
            accq_in  = 24'((acc_ff + (ACC_W'(1) <<< 29)) >>> 30);
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            y_in     = accq_ff * gain_ff;
            state_in = ST_FIN3;
         end
         ST_FIN3: begin
            res_smp_in = 1'b1;
            if (y_round > 28'sd32767) begin
               res_data_in = 16'h7FFF;
               res_clip_in = 1'b1;
            end else if (y_round < -28'sd32768) begin
               res_data_in = 16'h8000;
               res_clip_in = 1'b1;
            end else begin
               res_data_in = y_round[15:0];
               res_clip_in = 1'b0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_smp_in   = res_smp_ff;
               rsp_clip_in  = res_clip_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // a seed write reloads the generator at once
      if (csr_we && (reg_index_type'(csr_index) == REG_SEED))
         lfsr_in = (csr_wdata == 32'd0) ? 32'd1 : csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         read_low_ff  <= 16'd0;
         read_high_ff <= 16'hFFFF;
         dur_low_ff   <= 16'd96;
         dur_high_ff  <= 16'd96;
         layers_ff    <= LCNT_W'(MAX_LAYERS);
         gain_ff      <= 16'sd4096;
         lfsr_ff      <= 32'd1;
         draw_ff      <= '1;
         for (int i = 0; i < MAX_LAYERS; i++) begin
            phase_ff[i] <= '0;
            step_ff[i]  <= '0;
            pos_ff[i]   <= '0;
            start_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lfsr_ff      <= lfsr_in;
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_READ_LOW:  read_low_ff  <= csr_wdata[15:0];
               REG_READ_HIGH: read_high_ff <= csr_wdata[15:0];
               REG_DUR_LOW:   dur_low_ff   <= csr_wdata[15:0];
               REG_DUR_HIGH:  dur_high_ff  <= csr_wdata[15:0];
               REG_LAYERS: begin
                  if (csr_wdata[4:0] == 5'd0)
                     layers_ff <= LCNT_W'(1);
                  else if (32'(csr_wdata[4:0]) > 32'(MAX_LAYERS))
                     layers_ff <= LCNT_W'(MAX_LAYERS);
                  else
                     layers_ff <= LCNT_W'(csr_wdata[4:0]);
               end
               REG_GAIN:      gain_ff      <= csr_wdata[15:0];
               REG_SEED:      ;   // reloads the generator in the sequencer
               default: ;
            endcase
         end
         if (set_step)
            step_ff[g_ff] <= div_rsp.quotient[PHASE_W-1:0];
         if (set_pos) begin
            pos_ff[g_ff]   <= rlo + div_rsp.remainder[15:0];
            start_ff[g_ff] <= rlo + div_rsp.remainder[15:0];
            draw_ff[g_ff]  <= 1'b0;
         end
         if (upd_grain) begin
            phase_ff[g_ff] <= phase_new;
            pos_ff[g_ff]   <= pos_new;
         end
      end
      g_ff        <= g_in;
      redraw_ff   <= redraw_in;
      dur_ff      <= dur_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      accq_ff     <= accq_in;
      y_ff        <= y_in;
      res_data_ff <= res_data_in;
      res_smp_ff  <= res_smp_in;
      res_clip_ff <= res_clip_in;
      rsp_data_ff <= rsp_data_in;
      rsp_smp_ff  <= rsp_smp_in;
      rsp_clip_ff <= rsp_clip_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_clip_ff, rsp_smp_ff};
endmodule
